### rtl/core/t16rc_pkg.sv
// Shared constants for the Thumb 16-bit relocation classifier.
package t16rc_pkg;

  typedef logic [15:0] insn_t;
  typedef logic [2:0]  reloc_class_t;

  localparam reloc_class_t CLS_NONE    = 3'd0;
  localparam reloc_class_t CLS_GENERIC = 3'd1;
  localparam reloc_class_t CLS_LITERAL = 3'd2;
  localparam reloc_class_t CLS_ADR     = 3'd3;
  localparam reloc_class_t CLS_CBZ     = 3'd4;
  localparam reloc_class_t CLS_BCOND   = 3'd5;
  localparam reloc_class_t CLS_B       = 3'd6;
  localparam reloc_class_t CLS_BLXREG  = 3'd7;

  localparam logic [3:0] REG_PC = 4'hf;

  // High-register data processing opcodes (bits 9:8)
  localparam logic [1:0] HOP_ADD = 2'd0;
  localparam logic [1:0] HOP_CMP = 2'd1;
  localparam logic [1:0] HOP_MOV = 2'd2;
  localparam logic [1:0] HOP_BX  = 2'd3;

endpackage

### rtl/core/thumb16_relocation_classifier.sv
// Top level: classifies one Thumb halfword per transaction into a relocation class.
//
//   Channel  Ports                               Direction
//   input    in_valid, in_stall, in_instruction  in (in_stall out)
//   result   out_valid, out_stall,               out (out_stall in)
//            out_relocation_class
//
// One transaction per cycle sustained while out_stall is low; an accepted
// halfword passes the input register, then the result register. The decode
// is a shallow priority match between the two registers. Reset clears both
// valid flags. A stalled result holds in the result register; the input register
// keeps taking a new transaction until it too is full; in_stall follows from that.
module thumb16_relocation_classifier (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [15:0]             in_instruction,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [2:0]              out_relocation_class
);

  logic                   s1_valid_r, s1_valid_nxt;
  t16rc_pkg::insn_t       s1_insn_r;
  logic                   out_valid_r, out_valid_nxt;
  t16rc_pkg::reloc_class_t out_class_r;
  t16rc_pkg::reloc_class_t cls;
  logic                   out_free;
  logic                   in_take;

  // Handshake and pipeline advance
  assign out_free      = !out_valid_r || !out_stall;
  assign in_stall      = s1_valid_r && !out_free;
  assign in_take       = in_valid && !in_stall;
  assign s1_valid_nxt  = in_take || (s1_valid_r && !out_free);
  assign out_valid_nxt = (s1_valid_r && out_free) || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_insn_r <= in_instruction;
    end
    if (out_free) begin
      out_class_r <= cls;
    end
  end

  // Priority decode of the registered halfword
  always_comb begin
    logic [1:0] hop;
    logic [3:0] rm;
    logic [3:0] rn;
    logic [7:0] rlist;
    logic [2:0] rbase;
    hop   = s1_insn_r[9:8];
    rm    = s1_insn_r[6:3];
    rn    = {s1_insn_r[7], s1_insn_r[2:0]};
    rlist = s1_insn_r[7:0];
    rbase = s1_insn_r[10:8];
    cls   = t16rc_pkg::CLS_NONE;
    priority if (s1_insn_r[15:14] == 2'b00) begin
      cls = t16rc_pkg::CLS_GENERIC;
    end else if (s1_insn_r[15:10] == 6'b010000) begin
      cls = t16rc_pkg::CLS_GENERIC;
    end else if (s1_insn_r[15:10] == 6'b010001) begin
      // High-register ADD/CMP/MOV/BX
      unique case (hop)
        t16rc_pkg::HOP_ADD: begin
          cls = (rn != t16rc_pkg::REG_PC && rm != t16rc_pkg::REG_PC)
              ? t16rc_pkg::CLS_GENERIC : t16rc_pkg::CLS_NONE;
        end
        t16rc_pkg::HOP_CMP: begin
          if (rn == t16rc_pkg::REG_PC || rm == t16rc_pkg::REG_PC) begin
            cls = t16rc_pkg::CLS_NONE;
          end else if (!rn[3] && !rm[3]) begin
            cls = t16rc_pkg::CLS_NONE;
          end else begin
            cls = t16rc_pkg::CLS_GENERIC;
          end
        end
        t16rc_pkg::HOP_MOV: begin
          cls = (rm == t16rc_pkg::REG_PC) ? t16rc_pkg::CLS_NONE : t16rc_pkg::CLS_GENERIC;
        end
        t16rc_pkg::HOP_BX: begin
          // SBZ bits must be clear; bit 7 marks the link form
          if (s1_insn_r[2:0] != 3'd0) begin
            cls = t16rc_pkg::CLS_NONE;
          end else begin
            cls = s1_insn_r[7] ? t16rc_pkg::CLS_BLXREG : t16rc_pkg::CLS_GENERIC;
          end
        end
        default: cls = t16rc_pkg::CLS_NONE;
      endcase
    end else if (s1_insn_r[15:11] == 5'b01001) begin
      cls = t16rc_pkg::CLS_LITERAL;
    end else if (s1_insn_r[15:12] == 4'b0101) begin
      cls = t16rc_pkg::CLS_GENERIC;
    end else if (s1_insn_r[15:13] == 3'b011) begin
      cls = t16rc_pkg::CLS_GENERIC;
    end else if (s1_insn_r[15:13] == 3'b100) begin
      cls = t16rc_pkg::CLS_GENERIC;
    end else if (s1_insn_r[15:11] == 5'b10101) begin
      cls = t16rc_pkg::CLS_GENERIC;
    end else if (s1_insn_r[15:11] == 5'b10100) begin
      cls = t16rc_pkg::CLS_ADR;
    end else if (s1_insn_r[15:12] == 4'b1011) begin
      // Miscellaneous group; PUSH/POP and CBZ/CBNZ ignore bit 11
      priority if (s1_insn_r[11:8] == 4'b0000) begin
        cls = t16rc_pkg::CLS_GENERIC;
      end else if (s1_insn_r[10:9] == 2'b10) begin
        cls = t16rc_pkg::CLS_GENERIC;
      end else if (s1_insn_r[11:8] == 4'b1110) begin
        cls = t16rc_pkg::CLS_GENERIC;
      end else if (!s1_insn_r[10] && s1_insn_r[8]) begin
        cls = t16rc_pkg::CLS_CBZ;
      end else begin
        cls = t16rc_pkg::CLS_NONE;
      end
    end else if (s1_insn_r[15:12] == 4'b1100) begin
      // LDM/STM: reject empty list or list holding the base
      if (rlist == 8'd0 || rlist[rbase]) begin
        cls = t16rc_pkg::CLS_NONE;
      end else begin
        cls = t16rc_pkg::CLS_GENERIC;
      end
    end else if (s1_insn_r[15:12] == 4'b1101) begin
      priority if (s1_insn_r[11:8] == 4'b1111) begin
        cls = t16rc_pkg::CLS_GENERIC;
      end else if (s1_insn_r[11:8] == 4'b1110) begin
        cls = t16rc_pkg::CLS_NONE;
      end else begin
        cls = t16rc_pkg::CLS_BCOND;
      end
    end else if (s1_insn_r[15:11] == 5'b11101 && s1_insn_r[0]) begin
      cls = t16rc_pkg::CLS_NONE;
    end else if (s1_insn_r[15:11] == 5'b11100) begin
      cls = t16rc_pkg::CLS_B;
    end else begin
      // 32-bit prefixes and anything left
      cls = t16rc_pkg::CLS_NONE;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_relocation_class = out_class_r;

endmodule

### test/tb_thumb16_relocation_classifier.sv
// Testbench for the Thumb 16-bit relocation classifier: random and directed halfwords.
module tb_thumb16_relocation_classifier;

  localparam int RANDOM_ITEMS  = 2000;
  localparam int DRAIN_AT      = 1300;
  localparam int HOLD_AT       = 600;
  localparam int HOLD_CYCLES   = 300;
  localparam int IDLE_LIMIT    = 3000;
  localparam int SETTLE_CYCLES = 10;

  // Directed halfwords: field extremes and every special case of the decode
  localparam int N_DIRECTED = 30;
  localparam t16rc_pkg::insn_t DIRECTED_INSNS [N_DIRECTED] = '{
    16'h0000, 16'hffff, 16'h4011,
    16'h4411, 16'h4478, 16'h44ff,            // ADD high: no PC, one PC, both PC
    16'h4508, 16'h4540, 16'h457f,            // CMP high: both low, one high, PC
    16'h4678, 16'h4687,                      // MOV high: source PC, dest PC
    16'h4770, 16'h47f0, 16'h4771,            // BX, BLX, nonzero low bits
    16'h4800, 16'ha000, 16'ha800,
    16'hb000, 16'hb400, 16'hbe00, 16'hb100, 16'hb900, 16'hbf00, 16'hba00,
    16'hc800, 16'hc801, 16'hc802,            // LDM/STM: empty, holds base, clean
    16'hdf00, 16'hde00, 16'he801
  };

  typedef struct {
    t16rc_pkg::insn_t        insn;
    t16rc_pkg::reloc_class_t cls;
  } class_exp_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  t16rc_pkg::insn_t        in_instruction = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  t16rc_pkg::reloc_class_t out_relocation_class;

  t16rc_pkg::insn_t pending_insn_q [$];
  class_exp_t       expected_class_q [$];
  int               mismatch_count = 0;
  int               sent_count = 0;
  int               result_count = 0;

  thumb16_relocation_classifier DUT (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_instruction       (in_instruction),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_relocation_class (out_relocation_class)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Predicted relocation class of one halfword, in decode priority order
  function automatic t16rc_pkg::reloc_class_t classify_halfword(t16rc_pkg::insn_t insn);
    logic [3:0] rm;
    logic [3:0] rn;
    logic [7:0] reg_list;
    logic [2:0] base;
    rm       = insn[6:3];
    rn       = {insn[7], insn[2:0]};
    reg_list = insn[7:0];
    base     = insn[10:8];
    if (insn[15:14] == 2'b00) return t16rc_pkg::CLS_GENERIC;
    if (insn[15:10] == 6'b010000) return t16rc_pkg::CLS_GENERIC;
    if (insn[15:10] == 6'b010001) begin
      case (insn[9:8])
        t16rc_pkg::HOP_ADD: begin
          if (rn == t16rc_pkg::REG_PC || rm == t16rc_pkg::REG_PC) return t16rc_pkg::CLS_NONE;
          return t16rc_pkg::CLS_GENERIC;
        end
        t16rc_pkg::HOP_CMP: begin
          if (rn == t16rc_pkg::REG_PC || rm == t16rc_pkg::REG_PC) return t16rc_pkg::CLS_NONE;
          if (!rn[3] && !rm[3]) return t16rc_pkg::CLS_NONE;
          return t16rc_pkg::CLS_GENERIC;
        end
        t16rc_pkg::HOP_MOV: begin
          if (rm == t16rc_pkg::REG_PC) return t16rc_pkg::CLS_NONE;
          return t16rc_pkg::CLS_GENERIC;
        end
        default: begin
          if (insn[2:0] != 3'b000) return t16rc_pkg::CLS_NONE;
          return insn[7] ? t16rc_pkg::CLS_BLXREG : t16rc_pkg::CLS_GENERIC;
        end
      endcase
    end
    if (insn[15:11] == 5'b01001) return t16rc_pkg::CLS_LITERAL;
    if (insn[15:12] == 4'b0101) return t16rc_pkg::CLS_GENERIC;
    if (insn[15:13] == 3'b011) return t16rc_pkg::CLS_GENERIC;
    if (insn[15:13] == 3'b100) return t16rc_pkg::CLS_GENERIC;
    if (insn[15:11] == 5'b10101) return t16rc_pkg::CLS_GENERIC;
    if (insn[15:11] == 5'b10100) return t16rc_pkg::CLS_ADR;
    // Miscellaneous group
    if (insn[15:12] == 4'b1011) begin
      if (insn[11:8] == 4'b0000) return t16rc_pkg::CLS_GENERIC;
      if (insn[10:9] == 2'b10) return t16rc_pkg::CLS_GENERIC;
      if (insn[11:8] == 4'b1110) return t16rc_pkg::CLS_GENERIC;
      if (!insn[10] && insn[8]) return t16rc_pkg::CLS_CBZ;
      return t16rc_pkg::CLS_NONE;
    end
    // LDM/STM: reject empty list or writeback into a listed base
    if (insn[15:12] == 4'b1100) begin
      if (reg_list == 8'h00) return t16rc_pkg::CLS_NONE;
      if (reg_list[base]) return t16rc_pkg::CLS_NONE;
      return t16rc_pkg::CLS_GENERIC;
    end
    if (insn[15:12] == 4'b1101) begin
      if (insn[11:8] == 4'b1111) return t16rc_pkg::CLS_GENERIC;
      if (insn[11:8] == 4'b1110) return t16rc_pkg::CLS_NONE;
      return t16rc_pkg::CLS_BCOND;
    end
    if (insn[15:11] == 5'b11101 && insn[0]) return t16rc_pkg::CLS_NONE;
    if (insn[15:11] == 5'b11100) return t16rc_pkg::CLS_B;
    return t16rc_pkg::CLS_NONE;
  endfunction

  // Sender: bursts of random length with random gaps, one drain pause
  int  burst_left = 0;
  int  gap_left = 0;
  bit  draining = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        void'(pending_insn_q.pop_front());
        sent_count <= sent_count + 1;
        if (sent_count + 1 == DRAIN_AT) draining = 1'b1;
      end
      if (in_valid && in_stall) begin
        // stalled transaction holds
      end else if (draining && expected_class_q.size() != 0) begin
        in_valid <= 1'b0;
      end else begin
        draining = 1'b0;
        if (burst_left == 0) begin
          burst_left = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end
        if (gap_left > 0 || pending_insn_q.size() == 0) begin
          if (gap_left > 0) gap_left--;
          in_valid <= 1'b0;
        end else begin
          burst_left--;
          in_valid       <= 1'b1;
          in_instruction <= pending_insn_q[0];
        end
      end
    end
  end

  // Receiver: stall pattern in phases, plus one long hold-off
  int  rx_phase_left = 0;
  int  rx_mode = 0;
  int  hold_left = 0;
  bit  hold_done = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (!hold_done && result_count >= HOLD_AT) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else begin
      if (rx_phase_left == 0) begin
        rx_mode       = $urandom_range(0, 3);
        rx_phase_left = $urandom_range(5, 80);
      end
      rx_phase_left--;
      case (rx_mode)
        0:       out_stall <= 1'b0;
        1:       out_stall <= ($urandom_range(0, 1) == 0);
        2:       out_stall <= ($urandom_range(0, 4) != 0);
        default: out_stall <= ($urandom_range(0, 5) == 0);
      endcase
    end
  end

  // Monitor: record accepted inputs, check accepted results in order
  always @(posedge clk) begin
    class_exp_t exp_item;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        exp_item.insn = in_instruction;
        exp_item.cls  = classify_halfword(in_instruction);
        expected_class_q.push_back(exp_item);
      end
      if (out_valid === 1'b1 && !out_stall) begin
        result_count <= result_count + 1;
        if (expected_class_q.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected result, expected none, actual class %0d",
                   $time, out_relocation_class);
        end else begin
          exp_item = expected_class_q.pop_front();
          if (out_relocation_class !== exp_item.cls) begin
            mismatch_count++;
            $display("%0t: insn %h class mismatch, expected %0d, actual %0d",
                     $time, exp_item.insn, exp_item.cls, out_relocation_class);
          end
        end
      end
    end
  end

  // Watchdog on cycles with no transaction on either channel
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid === 1'b1 && !out_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("tb_thumb16_relocation_classifier: FAIL");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Stimulus and end of run
  initial begin
    logic [31:0]      r;
    t16rc_pkg::insn_t insn;
    foreach (DIRECTED_INSNS[i]) pending_insn_q.push_back(DIRECTED_INSNS[i]);
    // Random halfwords, most aimed at the groups with operand checks
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      r = $urandom;
      case ($urandom_range(0, 7))
        1:       insn = {6'b010001, r[9:0]};
        2:       insn = {8'b01000111, r[7:3], r[8] ? 3'b000 : r[2:0]};
        3:       insn = {4'b1011, r[11:0]};
        4:       insn = {4'b1100, r[11:0]};
        5:       insn = {4'b1101, r[11:0]};
        6:       insn = {4'b1110, r[11:0]};
        default: insn = r[15:0];
      endcase
      pending_insn_q.push_back(insn);
    end
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    while (pending_insn_q.size() != 0 || in_valid) @(posedge clk);
    while (expected_class_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_class_q.size() == 0) begin
      $display("tb_thumb16_relocation_classifier: PASS");
    end else begin
      $display("tb_thumb16_relocation_classifier: FAIL");
    end
    $finish;
  end

endmodule
